// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the unit sphere intersection RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");

// The condition must never be seen at a clock edge.
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion violated");

`endif

// ----- rtl/usi_pkg.sv -----
// Types, codes and constants of the unit sphere intersection pipeline.
// No dependencies; imported by every module of the block.
package usi_pkg;

  localparam logic [1:0] OP_POINT = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;

  localparam logic [1:0] ST_MISS  = 2'd0;
  localparam logic [1:0] ST_HIT   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  localparam int NUM_AXES   = 3;
  localparam int NUM_LANES  = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_BITS   = 16;
  localparam int DEN_W      = 34;
  localparam int PRD_W      = 51;
  localparam int TOT_W      = 52;
  localparam int MAG_W      = 51;

  localparam logic [31:0] ONE_SQ = 32'd16777216;

  typedef logic signed [15:0] coord_t;

  localparam coord_t COORD_MAX = 16'sh7fff;
  localparam coord_t COORD_MIN = 16'sh8000;

  typedef struct packed {
    logic [1:0] operation;
    coord_t     point_x;
    coord_t     point_y;
    coord_t     point_z;
    coord_t     dir_x;
    coord_t     dir_y;
    coord_t     dir_z;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     first_z;
    coord_t     second_x;
    coord_t     second_y;
    coord_t     second_z;
  } rsp_t;

  // Travels beside the square root: everything the line solution needs.
  typedef struct packed {
    logic [1:0]           status;
    logic                 line_hit;
    coord_t [2:0]         p;
    coord_t [2:0]         d;
    logic signed [32:0]   h;
    logic [31:0]          a;
  } dot_sb_t;

  // Travels beside the dividers.
  typedef struct packed {
    logic [1:0]   status;
    logic         line_hit;
    coord_t [2:0] echo;
  } lane_sb_t;

  // Signed quotient from magnitude, overflow flag and sign, clamped to Q3.12.
  function automatic coord_t sat_coord(input logic [DIV_BITS-1:0] q, input logic ovf,
                                       input logic neg);
    coord_t r;
    if (ovf || q[DIV_BITS-1]) begin
      r = neg ? COORD_MIN : COORD_MAX;
    end else begin
      r = neg ? coord_t'(16'd0 - q) : coord_t'(q);
    end
    return r;
  endfunction

endpackage

// ----- rtl/usi_dot.sv -----
// Front end of the intersection pipeline: dot products, discriminant and status.
// Depends on usi_pkg.
module usi_dot (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  usi_pkg::req_t    req,
  output logic             out_valid,
  output usi_pkg::dot_sb_t out_sb,
  output logic [63:0]      rad
);
  import usi_pkg::*;

  coord_t pin [NUM_AXES];
  coord_t din [NUM_AXES];

  logic               v1, v2, v3, v4;
  req_t               req1, req2, req3;
  logic signed [31:0] pp1 [NUM_AXES];
  logic signed [31:0] dd1 [NUM_AXES];
  logic signed [31:0] dp1 [NUM_AXES];
  logic [31:0]        a2, len2, a3;
  logic signed [32:0] h2, h3;
  logic [31:0]        habs, cabs;
  logic               cneg;
  logic [63:0]        hh3, ac3;
  logic               cneg3, phit3;
  logic [63:0]        quarter;
  logic               line_ok;
  logic [1:0]         status_next;
  dot_sb_t            sb4;
  logic [63:0]        rad4;

  assign pin[0] = req.point_x;
  assign pin[1] = req.point_y;
  assign pin[2] = req.point_z;
  assign din[0] = req.dir_x;
  assign din[1] = req.dir_y;
  assign din[2] = req.dir_z;

  // Stage 1: the nine 16x16 products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      req1 <= req;
      for (int i = 0; i < NUM_AXES; i++) begin
        pp1[i] <= 32'(pin[i]) * 32'(pin[i]);
        dd1[i] <= 32'(din[i]) * 32'(din[i]);
        dp1[i] <= 32'(din[i]) * 32'(pin[i]);
      end
    end
  end

  // Stage 2: the three sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      req2 <= req1;
      a2   <= 32'(dd1[0]) + 32'(dd1[1]) + 32'(dd1[2]);
      len2 <= 32'(pp1[0]) + 32'(pp1[1]) + 32'(pp1[2]);
      h2   <= 33'(dp1[0]) + 33'(dp1[1]) + 33'(dp1[2]);
    end
  end

  // Stage 3: h squared and a times |c|.
  always_comb begin
    habs = h2[32] ? 32'(-h2) : h2[31:0];
    cneg = len2 < ONE_SQ;
    cabs = cneg ? (ONE_SQ - len2) : (len2 - ONE_SQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      req3  <= req2;
      a3    <= a2;
      h3    <= h2;
      hh3   <= {32'd0, habs} * {32'd0, habs};
      ac3   <= {32'd0, a2} * {32'd0, cabs};
      cneg3 <= cneg;
      phit3 <= len2 <= ONE_SQ;
    end
  end

  // Stage 4: quarter discriminant and the status of the request.
  always_comb begin
    quarter = cneg3 ? (hh3 + ac3) : (hh3 - ac3);
    line_ok = (a3 != 32'd0) && (cneg3 || (hh3 >= ac3));
    unique case (req3.operation)
      OP_POINT: status_next = phit3 ? ST_HIT : ST_MISS;
      OP_LINE:  status_next = line_ok ? ST_HIT : ST_MISS;
      default:  status_next = ST_UNSUP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      sb4.status   <= status_next;
      sb4.line_hit <= (req3.operation == OP_LINE) && line_ok;
      sb4.p[0]     <= req3.point_x;
      sb4.p[1]     <= req3.point_y;
      sb4.p[2]     <= req3.point_z;
      sb4.d[0]     <= req3.dir_x;
      sb4.d[1]     <= req3.dir_y;
      sb4.d[2]     <= req3.dir_z;
      sb4.h        <= h3;
      sb4.a        <= a3;
      rad4         <= {quarter[61:0], 2'b00};
    end
  end

  assign out_valid = v4;
  assign out_sb    = sb4;
  assign rad       = rad4;

endmodule

// ----- rtl/usi_sqrt.sv -----
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on usi_pkg and assert_macros.svh.
module usi_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  usi_pkg::dot_sb_t in_sb,
  input  logic [63:0]      rad,
  output logic             out_valid,
  output usi_pkg::dot_sb_t out_sb,
  output logic [31:0]      root
);
  import usi_pkg::*;
  `include "assert_macros.svh"

  logic        sv   [SQRT_STEPS];
  dot_sb_t     ssb  [SQRT_STEPS];
  logic [63:0] srem [SQRT_STEPS];
  logic [63:0] sres [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BITV = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
    logic        cv;
    dot_sb_t     csb;
    logic [63:0] crem, cres;
    logic [64:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign cv   = in_valid;
      assign csb  = in_sb;
      assign crem = rad;
      assign cres = 64'd0;
    end else begin : g_next
      assign cv   = sv[k-1];
      assign csb  = ssb[k-1];
      assign crem = srem[k-1];
      assign cres = sres[k-1];
    end

    assign trial = {1'b0, cres} + {1'b0, BITV};
    assign take  = {1'b0, crem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= cv;
      end
      if (en) begin
        ssb[k]  <= csb;
        srem[k] <= take ? (crem - trial[63:0]) : crem;
        sres[k] <= take ? ((cres >> 1) + BITV) : (cres >> 1);
      end
    end
  end

  assign out_valid = sv[SQRT_STEPS-1];
  assign out_sb    = ssb[SQRT_STEPS-1];
  assign root      = sres[SQRT_STEPS-1][31:0];

  // The root of a 64-bit value never needs more than 32 bits.
  `ASSERT_NEVER(a_root_fits, clk, rst, out_valid && (sres[SQRT_STEPS-1][63:32] != 32'd0))

endmodule

// ----- rtl/usi_along.sv -----
// Forms the six numerators p*2a + n*d and splits them into sign and magnitude.
// Depends on usi_pkg and assert_macros.svh.
module usi_along (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  usi_pkg::dot_sb_t                                in_sb,
  input  logic [31:0]                                     root,
  output logic                                            out_valid,
  output usi_pkg::lane_sb_t                               out_sb,
  output logic [usi_pkg::DEN_W-1:0]                       den,
  output logic [usi_pkg::NUM_LANES-1:0][usi_pkg::MAG_W-1:0] mag,
  output logic [usi_pkg::NUM_LANES-1:0]                   neg
);
  import usi_pkg::*;
  `include "assert_macros.svh"

  logic               va, vb, vc;
  dot_sb_t            sba, sbb;
  logic signed [34:0] n1a, n2a;
  logic [DEN_W-1:0]   dena, denb, denc;
  logic signed [PRD_W-1:0] prd [NUM_AXES];
  logic signed [PRD_W-1:0] nd  [NUM_LANES];
  logic signed [TOT_W-1:0] tot [NUM_LANES];
  lane_sb_t           sbc;
  logic [NUM_LANES-1:0][MAG_W-1:0] magc;
  logic [NUM_LANES-1:0] negc;

  // Stage A: numerators -2h +/- root and the denominator 2a.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      sba  <= in_sb;
      n1a  <= -(35'(in_sb.h) <<< 1) + $signed({3'b000, root});
      n2a  <= -(35'(in_sb.h) <<< 1) - $signed({3'b000, root});
      dena <= {1'b0, in_sb.a, 1'b0};
    end
  end

  // Stage B: p*den and n*d products.
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      sbb  <= sba;
      denb <= dena;
      for (int i = 0; i < NUM_AXES; i++) begin
        prd[i]            <= PRD_W'($signed(sba.p[i])) * PRD_W'($signed({1'b0, dena}));
        nd[i]             <= PRD_W'(n1a) * PRD_W'($signed(sba.d[i]));
        nd[i + NUM_AXES]  <= PRD_W'(n2a) * PRD_W'($signed(sba.d[i]));
      end
    end
  end

  // Stage C: sums, then sign and magnitude for the dividers.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      tot[l] = TOT_W'(prd[l % NUM_AXES]) + TOT_W'(nd[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
    if (en) begin
      denc         <= denb;
      sbc.status   <= sbb.status;
      sbc.line_hit <= sbb.line_hit;
      sbc.echo     <= ((sbb.status == ST_HIT) && !sbb.line_hit) ? sbb.p : '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        negc[l] <= tot[l][TOT_W-1];
        magc[l] <= tot[l][TOT_W-1] ? MAG_W'(-tot[l]) : MAG_W'(tot[l]);
      end
    end
  end

  assign out_valid = vc;
  assign out_sb    = sbc;
  assign den       = denc;
  assign mag       = magc;
  assign neg       = negc;

  // A line that hit always has a nonzero direction, so the divisor is nonzero.
  `ASSERT_IMPL(a_den_nonzero, clk, rst, va && sba.line_hit, dena != '0)

endmodule

// ----- rtl/usi_div.sv -----
// Six-lane pipelined restoring divider with an up-front overflow check.
// Depends on usi_pkg.
module usi_div (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic                                              in_valid,
  input  usi_pkg::lane_sb_t                                 in_sb,
  input  logic [usi_pkg::DEN_W-1:0]                         den,
  input  logic [usi_pkg::NUM_LANES-1:0][usi_pkg::MAG_W-1:0] mag,
  input  logic [usi_pkg::NUM_LANES-1:0]                     neg,
  output logic                                              out_valid,
  output usi_pkg::lane_sb_t                                 out_sb,
  output logic [usi_pkg::NUM_LANES-1:0][usi_pkg::DIV_BITS-1:0] quo,
  output logic [usi_pkg::NUM_LANES-1:0]                     ovf,
  output logic [usi_pkg::NUM_LANES-1:0]                     sgn
);
  import usi_pkg::*;

  logic                              dv    [DIV_BITS];
  lane_sb_t                          dsb   [DIV_BITS];
  logic [DEN_W-1:0]                  dden  [DIV_BITS];
  logic [NUM_LANES-1:0][MAG_W-1:0]   drem  [DIV_BITS];
  logic [NUM_LANES-1:0][DIV_BITS-1:0] dq   [DIV_BITS];
  logic [NUM_LANES-1:0]              dovf  [DIV_BITS];
  logic [NUM_LANES-1:0]              dneg  [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    localparam int SH = DIV_BITS - 1 - k;
    logic                              cv;
    lane_sb_t                          csb;
    logic [DEN_W-1:0]                  cden;
    logic [NUM_LANES-1:0][MAG_W-1:0]   crem;
    logic [NUM_LANES-1:0][DIV_BITS-1:0] cq;
    logic [NUM_LANES-1:0]              covf;
    logic [NUM_LANES-1:0]              cneg;
    logic [MAG_W-1:0]                  divisor;
    logic [NUM_LANES-1:0]              take;

    if (k == 0) begin : g_first
      assign cv   = in_valid;
      assign csb  = in_sb;
      assign cden = den;
      assign crem = mag;
      assign cq   = '0;
      assign cneg = neg;
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_ovf
        assign covf[l] = mag[l] >= (MAG_W'(den) << DIV_BITS);
      end
    end else begin : g_next
      assign cv   = dv[k-1];
      assign csb  = dsb[k-1];
      assign cden = dden[k-1];
      assign crem = drem[k-1];
      assign cq   = dq[k-1];
      assign covf = dovf[k-1];
      assign cneg = dneg[k-1];
    end

    assign divisor = MAG_W'(cden) << SH;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_take
      assign take[l] = crem[l] >= divisor;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= cv;
      end
      if (en) begin
        dsb[k]  <= csb;
        dden[k] <= cden;
        dovf[k] <= covf;
        dneg[k] <= cneg;
        for (int l = 0; l < NUM_LANES; l++) begin
          drem[k][l] <= take[l] ? (crem[l] - divisor) : crem[l];
          dq[k][l]   <= {cq[l][DIV_BITS-2:0], take[l]};
        end
      end
    end
  end

  assign out_valid = dv[DIV_BITS-1];
  assign out_sb    = dsb[DIV_BITS-1];
  assign quo       = dq[DIV_BITS-1];
  assign ovf       = dovf[DIV_BITS-1];
  assign sgn       = dneg[DIV_BITS-1];

endmodule

// ----- rtl/unit_sphere_intersect_core.sv -----
// A request passes through 4 dot, 32 root, 3 numerator and 16 divider stages
// and then the output register on its way to the result.
// Throughput: one request per cycle; a stalled output register freezes every stage.
// Reset (synchronous, active high) clears the valid bits only; data registers
// are not reset.
module unit_sphere_intersect_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  usi_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output usi_pkg::rsp_t rsp
);
  import usi_pkg::*;
  `include "assert_macros.svh"

  // The whole pipeline moves together. It advances whenever the output
  // register is empty or its result is being taken, so a new request enters
  // in the same cycle the previous result leaves.
  logic en;

  logic     dot_valid;
  dot_sb_t  dot_sb;
  logic [63:0] dot_rad;

  logic     sq_valid;
  dot_sb_t  sq_sb;
  logic [31:0] sq_root;

  logic     al_valid;
  lane_sb_t al_sb;
  logic [DEN_W-1:0] al_den;
  logic [NUM_LANES-1:0][MAG_W-1:0] al_mag;
  logic [NUM_LANES-1:0] al_neg;

  logic     dv_valid;
  lane_sb_t dv_sb;
  logic [NUM_LANES-1:0][DIV_BITS-1:0] dv_quo;
  logic [NUM_LANES-1:0] dv_ovf;
  logic [NUM_LANES-1:0] dv_sgn;

  rsp_t     rsp_next;
  coord_t   lane_val [NUM_LANES];

  assign en        = !rsp_valid || !rsp_stall;
  assign req_stall = rsp_valid && rsp_stall;

  // Dot products a, h, |p|^2, the discriminant and the request's status.
  usi_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .req       (req),
    .out_valid (dot_valid),
    .out_sb    (dot_sb),
    .rad       (dot_rad)
  );

  // Floor square root of the discriminant, one bit per stage.
  usi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dot_valid),
    .in_sb     (dot_sb),
    .rad       (dot_rad),
    .out_valid (sq_valid),
    .out_sb    (sq_sb),
    .root      (sq_root)
  );

  // Each output coordinate is (p*2a + n*d) / 2a; this forms the numerators.
  usi_along u_along (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_sb     (sq_sb),
    .root      (sq_root),
    .out_valid (al_valid),
    .out_sb    (al_sb),
    .den       (al_den),
    .mag       (al_mag),
    .neg       (al_neg)
  );

  // Six quotients, truncated toward zero, with an overflow flag per lane.
  usi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (al_valid),
    .in_sb     (al_sb),
    .den       (al_den),
    .mag       (al_mag),
    .neg       (al_neg),
    .out_valid (dv_valid),
    .out_sb    (dv_sb),
    .quo       (dv_quo),
    .ovf       (dv_ovf),
    .sgn       (dv_sgn)
  );

  // Lanes 0..2 carry the first intersection, lanes 3..5 the second. When the
  // request is not a line hit, the first point takes the echo field (the point, or zero) and the second is zero.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_val[l] = sat_coord(dv_quo[l], dv_ovf[l], dv_sgn[l]);
    end
    rsp_next.status   = dv_sb.status;
    rsp_next.first_x  = dv_sb.line_hit ? lane_val[0] : dv_sb.echo[0];
    rsp_next.first_y  = dv_sb.line_hit ? lane_val[1] : dv_sb.echo[1];
    rsp_next.first_z  = dv_sb.line_hit ? lane_val[2] : dv_sb.echo[2];
    rsp_next.second_x = dv_sb.line_hit ? lane_val[3] : '0;
    rsp_next.second_y = dv_sb.line_hit ? lane_val[4] : '0;
    rsp_next.second_z = dv_sb.line_hit ? lane_val[5] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= dv_valid;
    end
    if (en) begin
      rsp <= rsp_next;
    end
  end

  // A miss or an unsupported operation must never carry coordinates.
  `ASSERT_IMPL(a_miss_zero, clk, rst, rsp_valid && (rsp.status == ST_MISS), (rsp.first_x == '0) && (rsp.first_y == '0) && (rsp.first_z == '0) && (rsp.second_x == '0) && (rsp.second_y == '0) && (rsp.second_z == '0))
  `ASSERT_IMPL(a_unsup_zero, clk, rst, rsp_valid && (rsp.status == ST_UNSUP), (rsp.first_x == '0) && (rsp.first_y == '0) && (rsp.first_z == '0) && (rsp.second_x == '0) && (rsp.second_y == '0) && (rsp.second_z == '0))

endmodule
